>>> sv/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// No dependencies.
`default_nettype none
package ffha_pkg;

  localparam int HEAP_BYTES   = 4096;
  localparam int HEADER_BYTES = 24;
  localparam int GRAIN_BYTES  = 8;
  localparam int IDX_W        = $clog2(HEAP_BYTES / GRAIN_BYTES);
  localparam int SUM_W        = $clog2(HEAP_BYTES) + 2;
  localparam int SIZE_W       = 13;
  localparam int ENTRY_W      = SIZE_W + 1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Reset block: whole heap minus one header, rounded down to the grain
  localparam logic [SIZE_W-1:0] INIT_SIZE =
    SIZE_W'(((HEAP_BYTES - HEADER_BYTES) / GRAIN_BYTES) * GRAIN_BYTES);

  typedef struct packed {
    logic        kind;
    logic [11:0] request_bytes;
    logic [11:0] payload_offset;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] granted_offset;
  } out_t;

  // Header entry: payload size above, free mark in bit 0
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  typedef struct packed {
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    entry_t                   wdata;
    logic [IDX_W-1:0]         raddr;
  } mem_req_t;

endpackage
`default_nettype wire

>>> sv/ffha_store.sv
// Header store: one entry per 8-byte block start, one write and one read port,
// registered read. Entry 0 reads as the reset block until first written.
// Depends on ffha_pkg.
`default_nettype none
module ffha_store (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ffha_pkg::mem_req_t req,
  output ffha_pkg::entry_t       rdata
);

  localparam int DEPTH = 1 << ffha_pkg::IDX_W;

  ffha_pkg::entry_t mem_r [DEPTH];
  ffha_pkg::entry_t q_r;
  logic             e0_init_r;
  logic             rd_init_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    q_r <= mem_r[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_init_r <= 1'b1;
      rd_init_r <= 1'b0;
    end else begin
      rd_init_r <= e0_init_r && (req.raddr == '0);
      if (req.we && req.waddr == '0) begin
        e0_init_r <= 1'b0;
      end
    end
  end

  assign rdata = rd_init_r ? ffha_pkg::entry_t'{size: ffha_pkg::INIT_SIZE, free: 1'b1} : q_r;

endmodule
`default_nettype wire

>>> sv/first_fit_heap_allocator.sv
// First-fit heap allocator with split on allocate and full coalesce on free.
// An allocate walks the block headers from the heap base, with one more step when it splits;
// a free walks the headers to its block, then restarts at the heap base
// and reads each further header in the coalesce pass (a merge reads the next one too).
// The result strobe follows in the next cycle; one operation at a time, busy high until it.
// Reset: synchronous active low; the heap becomes one free block, no clearing pass.
`default_nettype none
module first_fit_heap_allocator (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire ffha_pkg::in_t  in_data,
  output logic                out_valid,
  output ffha_pkg::out_t      out_data
);

  localparam int SW = ffha_pkg::SUM_W;
  localparam logic [SW-1:0] HDR  = SW'(ffha_pkg::HEADER_BYTES);
  localparam logic [SW-1:0] GRN  = SW'(ffha_pkg::GRAIN_BYTES);
  localparam logic [SW-1:0] HEAP = SW'(ffha_pkg::HEAP_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_ALOOK, S_ASPLIT, S_FLOOK, S_CSTART, S_CFIRST, S_CLOOK
  } state_t;

  state_t                       state_r, state_nxt;
  logic [11:0]                  at_r, at_nxt;
  logic [ffha_pkg::SIZE_W-1:0]  want_r, want_nxt;
  logic [11:0]                  poff_r, poff_nxt;
  logic [ffha_pkg::SIZE_W-1:0]  cur_size_r, cur_size_nxt;
  logic                         cur_free_r, cur_free_nxt;
  logic                         out_valid_r, out_valid_nxt;
  ffha_pkg::out_t               out_r, out_nxt;

  ffha_pkg::mem_req_t           mreq;
  ffha_pkg::entry_t             rd;

  logic [SW-1:0] at_w, nx_rd, nx_cur, merged;
  logic [SW-1:0] want_w, sz_w, nb;
  logic [SW-1:0] nx_mrg, nx_nxt;

  ffha_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rdata (rd)
  );

  assign at_w   = SW'(at_r);
  assign sz_w   = SW'(rd.size);
  assign want_w = SW'(want_r);
  assign nx_rd  = at_w + HDR + sz_w;
  assign nx_cur = at_w + HDR + SW'(cur_size_r);
  assign merged = SW'(cur_size_r) + HDR + sz_w;
  assign nb     = at_w + HDR + want_w;
  assign nx_mrg = at_w + HDR + merged;
  assign nx_nxt = nx_cur + HDR + sz_w;

  always_comb begin
    state_nxt     = state_r;
    at_nxt        = at_r;
    want_nxt      = want_r;
    poff_nxt      = poff_r;
    cur_size_nxt  = cur_size_r;
    cur_free_nxt  = cur_free_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mreq          = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          at_nxt   = '0;
          want_nxt = (ffha_pkg::SIZE_W'(in_data.request_bytes) + ffha_pkg::SIZE_W'(7))
                     & ~ffha_pkg::SIZE_W'(7);
          poff_nxt = in_data.payload_offset;
          if (in_data.kind == ffha_pkg::KIND_ALLOC) begin
            state_nxt = S_ALOOK;
          end else if (SW'(in_data.payload_offset) < HDR) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ffha_pkg::ST_BADFREE, granted_offset: '0};
          end else begin
            state_nxt = S_FLOOK;
          end
        end
      end

      S_ALOOK: begin
        if (rd.free && sz_w >= want_w) begin
          mreq.we = 1'b1;
          out_nxt = '{status: ffha_pkg::ST_OK, granted_offset: 12'(at_w + HDR)};
          if (sz_w >= want_w + HDR + GRN) begin
            // Split: new free block first, shrink this one next cycle
            mreq.waddr = nb[11:3];
            mreq.wdata = '{size: ffha_pkg::SIZE_W'(sz_w - want_w - HDR), free: 1'b1};
            state_nxt  = S_ASPLIT;
          end else begin
            mreq.waddr    = at_r[11:3];
            mreq.wdata    = '{size: rd.size, free: 1'b0};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (nx_rd >= HEAP) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ffha_pkg::ST_NOSPACE, granted_offset: '0};
          state_nxt     = S_IDLE;
        end else begin
          at_nxt     = nx_rd[11:0];
          mreq.raddr = nx_rd[11:3];
        end
      end

      S_ASPLIT: begin
        mreq.we       = 1'b1;
        mreq.waddr    = at_r[11:3];
        mreq.wdata    = '{size: want_r, free: 1'b0};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_FLOOK: begin
        if (at_w + HDR == SW'(poff_r)) begin
          if (rd.free) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ffha_pkg::ST_BADFREE, granted_offset: '0};
            state_nxt     = S_IDLE;
          end else begin
            mreq.we    = 1'b1;
            mreq.waddr = at_r[11:3];
            mreq.wdata = '{size: rd.size, free: 1'b1};
            state_nxt  = S_CSTART;
          end
        end else if (at_w + HDR > SW'(poff_r) || nx_rd >= HEAP) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ffha_pkg::ST_BADFREE, granted_offset: '0};
          state_nxt     = S_IDLE;
        end else begin
          at_nxt     = nx_rd[11:0];
          mreq.raddr = nx_rd[11:3];
        end
      end

      S_CSTART: begin
        // Read the first header after the free mark has landed
        at_nxt     = '0;
        mreq.raddr = '0;
        state_nxt  = S_CFIRST;
      end

      S_CFIRST: begin
        cur_size_nxt = rd.size;
        cur_free_nxt = rd.free;
        if (nx_rd >= HEAP) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{status: ffha_pkg::ST_OK, granted_offset: '0};
          state_nxt     = S_IDLE;
        end else begin
          mreq.raddr = nx_rd[11:3];
          state_nxt  = S_CLOOK;
        end
      end

      S_CLOOK: begin
        // rd holds the header right after the current block
        if (cur_free_r && rd.free) begin
          mreq.we      = 1'b1;
          mreq.waddr   = at_r[11:3];
          mreq.wdata   = '{size: ffha_pkg::SIZE_W'(merged), free: 1'b1};
          cur_size_nxt = ffha_pkg::SIZE_W'(merged);
          if (nx_mrg >= HEAP) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ffha_pkg::ST_OK, granted_offset: '0};
            state_nxt     = S_IDLE;
          end else begin
            mreq.raddr = nx_mrg[11:3];
          end
        end else begin
          at_nxt       = nx_cur[11:0];
          cur_size_nxt = rd.size;
          cur_free_nxt = rd.free;
          if (nx_nxt >= HEAP) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ffha_pkg::ST_OK, granted_offset: '0};
            state_nxt     = S_IDLE;
          end else begin
            mreq.raddr = nx_nxt[11:3];
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    at_r       <= at_nxt;
    want_r     <= want_nxt;
    poff_r     <= poff_nxt;
    cur_size_r <= cur_size_nxt;
    cur_free_r <= cur_free_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> tb/ffha_checker.sv
// Checker for the first-fit heap allocator: watches transfers and results,
// predicts each result from its own model of the block chain. Depends on ffha_pkg.
module ffha_checker (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic           busy,
  input  wire ffha_pkg::in_t  in_data,
  input  wire logic           out_valid,
  input  wire ffha_pkg::out_t out_data,
  output int                  fail_count,
  output int                  pending
);

  // Header per byte offset: size and free mark
  int unsigned     blk_size [ffha_pkg::HEAP_BYTES];
  bit              blk_free [ffha_pkg::HEAP_BYTES];
  ffha_pkg::out_t  expected_q [$];
  int              mismatch_count;

  function automatic int unsigned next_start(int unsigned at);
    return at + ffha_pkg::HEADER_BYTES + blk_size[at];
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i < ffha_pkg::HEAP_BYTES; i++) begin
      blk_size[i] = 0;
      blk_free[i] = 1'b0;
    end
    blk_size[0] = int'(ffha_pkg::INIT_SIZE);
    blk_free[0] = 1'b1;
  endfunction

  function automatic void merge_free_runs();
    int unsigned at;
    int unsigned nx;
    at = 0;
    while (at < ffha_pkg::HEAP_BYTES) begin
      nx = next_start(at);
      if (nx < ffha_pkg::HEAP_BYTES && blk_free[at] && blk_free[nx])
        blk_size[at] = blk_size[at] + ffha_pkg::HEADER_BYTES + blk_size[nx];
      else
        at = nx;
    end
  endfunction

  function automatic ffha_pkg::out_t predict_result(ffha_pkg::in_t item);
    ffha_pkg::out_t res;
    int unsigned    want;
    int unsigned    at;
    int unsigned    sz;
    int unsigned    nb;
    int unsigned    poff;
    bit             done;
    res = '0;
    done = 1'b0;
    at = 0;
    if (item.kind == ffha_pkg::KIND_ALLOC) begin
      want = (int'(item.request_bytes) + 7) & ~7;
      res.status = ffha_pkg::ST_NOSPACE;
      while (at < ffha_pkg::HEAP_BYTES && !done) begin
        sz = blk_size[at];
        if (blk_free[at] && sz >= want) begin
          if (sz >= want + ffha_pkg::HEADER_BYTES + 8) begin
            nb = at + ffha_pkg::HEADER_BYTES + want;
            if (nb < ffha_pkg::HEAP_BYTES) begin
              blk_size[nb] = sz - want - ffha_pkg::HEADER_BYTES;
              blk_free[nb] = 1'b1;
            end
            blk_size[at] = want;
          end
          blk_free[at] = 1'b0;
          res.status = ffha_pkg::ST_OK;
          res.granted_offset = 12'(at + ffha_pkg::HEADER_BYTES);
          done = 1'b1;
        end else begin
          at = next_start(at);
        end
      end
    end else begin
      poff = {20'd0, item.payload_offset};
      res.status = ffha_pkg::ST_BADFREE;
      if (poff >= ffha_pkg::HEADER_BYTES) begin
        while (at < ffha_pkg::HEAP_BYTES && !done) begin
          if (at + ffha_pkg::HEADER_BYTES == poff) begin
            if (!blk_free[at]) begin
              blk_free[at] = 1'b1;
              merge_free_runs();
              res.status = ffha_pkg::ST_OK;
            end
            done = 1'b1;
          end else if (at + ffha_pkg::HEADER_BYTES > poff) begin
            done = 1'b1;
          end else begin
            at = next_start(at);
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      heap_reset();
      expected_q.delete();
      fail_count <= 0;
      mismatch_count = 0;
      pending = 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (mismatch_count < 10)
            $display("unexpected result: status %0d offset %0d",
                     out_data.status, out_data.granted_offset);
          mismatch_count++;
        end else begin
          ffha_pkg::out_t exp_r;
          exp_r = expected_q.pop_front();
          if (exp_r.status !== out_data.status ||
              exp_r.granted_offset !== out_data.granted_offset) begin
            fail_count <= fail_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: expected status %0d offset %0d, got status %0d offset %0d",
                       exp_r.status, exp_r.granted_offset,
                       out_data.status, out_data.granted_offset);
            mismatch_count++;
          end
        end
      end
      if (start && !busy)
        expected_q.push_back(predict_result(in_data));
      pending = expected_q.size();
    end
  end
endmodule

>>> tb/tb.sv
// Top of the allocator testbench: drives allocate and free commands, gives the verdict.
// Depends on ffha_pkg, first_fit_heap_allocator and ffha_checker.
module tb;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  ffha_pkg::in_t  in_data;
  logic           out_valid;
  ffha_pkg::out_t out_data;
  int             fail_count;
  int             pending;
  int             cycle_count = 0;
  int             live_q [$];

  localparam int CYCLE_LIMIT = 4000000;

  first_fit_heap_allocator dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data
  );

  ffha_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever begin
      #6 clk = 1;
      #6 clk = 0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive one command and hold it until the transfer
  task automatic send_cmd(logic kind, logic [11:0] req, logic [11:0] poff, bit may_idle);
    while (may_idle && $urandom_range(99) < 17)
      @(posedge clk);
    start <= 1'b1;
    in_data <= '{kind: kind, request_bytes: req, payload_offset: poff};
    @(posedge clk);
    while (busy)
      @(posedge clk);
    start <= 1'b0;
    // Wait out the command so the returned offset can be tracked
    @(posedge clk);
    while (!out_valid)
      @(posedge clk);
    if (kind == ffha_pkg::KIND_ALLOC && out_data.status == ffha_pkg::ST_OK)
      live_q.push_back(int'(out_data.granted_offset));
  endtask

  task automatic send_alloc(logic [11:0] req, bit may_idle);
    send_cmd(ffha_pkg::KIND_ALLOC, req, 12'd0, may_idle);
  endtask

  task automatic send_free(logic [11:0] poff, bit may_idle);
    send_cmd(ffha_pkg::KIND_FREE, 12'd0, poff, may_idle);
  endtask

  initial begin
    int n;
    int idx;
    bit may_idle;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero request, oversize, bad frees
    send_alloc(12'd0, 0);
    send_alloc(12'd1, 0);
    send_alloc(12'd8, 0);
    send_alloc(12'd4095, 0);
    send_free(12'd0, 0);
    send_free(12'd23, 0);
    send_free(12'd4095, 0);
    send_free(12'd30, 0);
    send_free(12'd24, 0);
    send_free(12'd24, 0);
    send_alloc(12'd7, 0);
    send_alloc(12'd2000, 0);
    send_alloc(12'd2000, 0);
    send_alloc(12'd3000, 0);
    while (live_q.size() > 0)
      send_free(12'(live_q.pop_front()), 0);
    send_alloc(12'd4072, 0);
    send_alloc(12'd4064, 0);
    send_free(12'd24, 0);
    send_alloc(12'd4048, 0);
    send_alloc(12'd0, 0);
    while (live_q.size() > 0)
      send_free(12'(live_q.pop_front()), 0);

    // Random: mostly real frees and modest allocs, some noise
    for (int i = 0; i < 1150; i++) begin
      may_idle = !(i >= 400 && i < 600);
      n = $urandom_range(99);
      if (n < 45) begin
        if ($urandom_range(9) == 0)
          send_alloc(12'($urandom), may_idle);
        else
          send_alloc(12'($urandom_range(200)), may_idle);
      end else if (n < 85 && live_q.size() > 0) begin
        idx = $urandom_range(live_q.size() - 1);
        send_free(12'(live_q[idx]), may_idle);
        live_q.delete(idx);
      end else begin
        send_free(12'($urandom), may_idle);
      end
    end

    while (pending != 0)
      @(posedge clk);
    repeat (3000) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
